// ----- rtl/core/quadratic_root_solver_top_defines.svh -----
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared property wrappers for the solver pipeline checks
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define QRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/qrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// shared defaults, case codes and per-item classification for the solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CASE_TWO    = 3'd0,
        CASE_DOUBLE = 3'd1,
        CASE_NONE   = 3'd2,
        CASE_LINEAR = 3'd3,
        CASE_NOSOL  = 3'd4,
        CASE_INF    = 3'd5
    } t_case;

    typedef struct packed {
        t_case code;
        logic  a_neg;
        logic  b_pos;
        logic  lin_neg;
    } t_info;

endpackage

// ----- rtl/core/qrs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_if
// coefficient and root stream channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface qrs_coef_if #(parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if #(parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF);
    logic                        valid;
    logic                        ready;
    logic [2:0]                  case_code;
    logic signed [WORD_BITS-1:0] root_low;
    logic signed [WORD_BITS-1:0] root_high;
    logic                        saturated;

    modport source (output valid, output case_code, output root_low, output root_high,
                    output saturated, input ready);
    modport sink   (input valid, input case_code, input root_low, input root_high,
                    input saturated, output ready);
endinterface

// ----- rtl/core/quadratic_root_solver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
// Takes one coefficient transaction per cycle while the pipeline is not stalled
// and returns one root transaction per input, in order. The pipeline holds three
// prep stages, a square root that resolves one bit per stage, one numerator
// stage, a two-lane divider that resolves one quotient bit per stage, and two
// clamp/order stages. Stages advance independently, so bubbles collapse under
// output backpressure and a new transaction is taken whenever the first stage
// is free.
module quadratic_root_solver_top #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_coef_if.sink   i_coef,
    qrs_root_if.source o_root
);
    import qrs_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int IB   = $bits(t_info);
    localparam int SW   = W + F + 1;
    localparam int NM   = W + F + 1;
    localparam int NW   = NM + 1;
    localparam int SQ_S = IB + 3 * W;
    localparam int DV_S = IB + 2;

    // prep -> sqrt
    logic          pr_valid, pr_ready;
    t_info         pr_info;
    logic [W-1:0]  pr_ua, pr_ub, pr_uc;
    logic [2*W:0]  pr_disc;

    // sqrt -> numerator stage
    logic            sq_valid, sq_ready;
    logic [SW-1:0]   sq_root;
    logic [SQ_S-1:0] sq_side;
    t_info           sq_info;
    logic [W-1:0]    sq_ua, sq_ub, sq_uc;

    // numerator stage -> divider
    logic               r_nv;
    logic [1:0][NM-1:0] r_num;
    logic [W:0]         r_den;
    logic [DV_S-1:0]    r_dside;
    logic               dv_ready;

    // divider -> post
    logic               dv_valid, po_ready;
    logic [1:0][NM-1:0] dv_quo;
    logic [DV_S-1:0]    dv_side;

    qrs_prep #(.WORD_BITS(W)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_coef.valid),
        .o_ready  (i_coef.ready),
        .i_coef_a (i_coef.coef_a),
        .i_coef_b (i_coef.coef_b),
        .i_coef_c (i_coef.coef_c),
        .o_valid  (pr_valid),
        .i_ready  (pr_ready),
        .o_info   (pr_info),
        .o_ua     (pr_ua),
        .o_ub     (pr_ub),
        .o_uc     (pr_uc),
        .o_disc   (pr_disc)
    );

    qrs_sqrt #(.WORD_BITS(W), .FRAC_BITS(F), .SIDE_BITS(SQ_S)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pr_valid),
        .o_ready (pr_ready),
        .i_disc  (pr_disc),
        .i_side  ({pr_info, pr_ua, pr_ub, pr_uc}),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign sq_info = t_info'(sq_side[3*W +: IB]);
    assign sq_ua   = sq_side[2*W +: W];
    assign sq_ub   = sq_side[W +: W];
    assign sq_uc   = sq_side[0 +: W];

    // signed numerators -b*2^F -/+ s (c*2^F over b in the linear case), split into magnitude and quotient sign
    logic [W+F-1:0]       nb_mag;
    logic signed [NW-1:0] nb_val, s_val, v_lo, v_hi, v_lo_n, v_hi_n;
    logic [1:0][NM-1:0]   n_num;
    logic [1:0]           n_neg;
    logic [W:0]           n_den;

    assign nb_mag = {sq_ub, {F{1'b0}}};
    assign nb_val = sq_info.b_pos ? -$signed({2'b00, nb_mag}) : $signed({2'b00, nb_mag});
    assign s_val  = $signed({1'b0, sq_root});
    assign v_lo   = nb_val - s_val;
    assign v_hi   = nb_val + s_val;
    assign v_lo_n = -v_lo;
    assign v_hi_n = -v_hi;

    always_comb begin
        if (sq_info.code == CASE_LINEAR) begin
            n_num[0] = {1'b0, sq_uc, {F{1'b0}}};
            n_num[1] = {1'b0, sq_uc, {F{1'b0}}};
            n_neg    = {2{sq_info.lin_neg}};
            n_den    = {1'b0, sq_ub};
        end else begin
            n_num[0] = v_lo[NW-1] ? v_lo_n[NM-1:0] : v_lo[NM-1:0];
            n_num[1] = v_hi[NW-1] ? v_hi_n[NM-1:0] : v_hi[NM-1:0];
            n_neg[0] = v_lo[NW-1] != sq_info.a_neg;
            n_neg[1] = v_hi[NW-1] != sq_info.a_neg;
            n_den    = {sq_ua, 1'b0};
        end
    end

    assign sq_ready = !r_nv || dv_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (sq_ready) begin
            r_nv <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_ready) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_dside <= {sq_info, n_neg};
        end
    end

    qrs_div #(.NUM_BITS(NM), .DEN_BITS(W + 1), .SIDE_BITS(DV_S)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_nv),
        .o_ready (dv_ready),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_dside),
        .o_valid (dv_valid),
        .i_ready (po_ready),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    qrs_post #(.WORD_BITS(W), .NUM_BITS(NM)) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid),
        .o_ready     (po_ready),
        .i_quo       (dv_quo),
        .i_neg       (dv_side[1:0]),
        .i_info      (t_info'(dv_side[2 +: IB])),
        .o_valid     (o_root.valid),
        .i_ready     (o_root.ready),
        .o_case_code (o_root.case_code),
        .o_root_low  (o_root.root_low),
        .o_root_high (o_root.root_high),
        .o_saturated (o_root.saturated)
    );

endmodule

// ----- rtl/core/qrs_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_prep
// magnitudes, products and discriminant with case classification (3 stages)
// ----------------------------------------------------------------------------
module qrs_prep #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_coef_a,
    input  logic signed [WORD_BITS-1:0] i_coef_b,
    input  logic signed [WORD_BITS-1:0] i_coef_c,
    output logic                        o_valid,
    input  logic                        i_ready,
    output qrs_pkg::t_info              o_info,
    output logic [WORD_BITS-1:0]        o_ua,
    output logic [WORD_BITS-1:0]        o_ub,
    output logic [WORD_BITS-1:0]        o_uc,
    output logic [2*WORD_BITS:0]        o_disc
);
    import qrs_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;

    typedef struct packed {
        logic an, bn, cn, az, bz, cz;
    } t_sign;

    logic [2:0] r_v;
    logic [3:0] rdy;

    logic [W-1:0] r0_ua, r0_ub, r0_uc;
    t_sign        r0_sg;
    logic [W-1:0] r1_ua, r1_ub, r1_uc;
    logic [PW-1:0] r1_bb, r1_ac;
    t_sign        r1_sg;
    logic [W-1:0] r2_ua, r2_ub, r2_uc;
    logic [DW-1:0] r2_disc;
    t_info        r2_info;

    logic [PW+1:0] bbx, ac4, sum, dif;
    logic          acneg;
    t_info         n_info;
    logic [DW-1:0] n_disc;

    assign rdy[3] = i_ready;
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign rdy[0] = !r_v[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
        end
    end

    // stage 0: magnitudes and sign flags
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_ua    <= i_coef_a[W-1] ? (~i_coef_a + 1'b1) : i_coef_a;
            r0_ub    <= i_coef_b[W-1] ? (~i_coef_b + 1'b1) : i_coef_b;
            r0_uc    <= i_coef_c[W-1] ? (~i_coef_c + 1'b1) : i_coef_c;
            r0_sg.an <= i_coef_a[W-1];
            r0_sg.bn <= i_coef_b[W-1];
            r0_sg.cn <= i_coef_c[W-1];
            r0_sg.az <= (i_coef_a == '0);
            r0_sg.bz <= (i_coef_b == '0);
            r0_sg.cz <= (i_coef_c == '0);
        end
    end

    // stage 1: b*b and a*c
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_bb <= r0_ub * r0_ub;
            r1_ac <= r0_ua * r0_uc;
            r1_ua <= r0_ua;
            r1_ub <= r0_ub;
            r1_uc <= r0_uc;
            r1_sg <= r0_sg;
        end
    end

    // stage 2: discriminant and classification
    assign bbx   = {2'b00, r1_bb};
    assign ac4   = {r1_ac, 2'b00};
    assign sum   = bbx + ac4;
    assign dif   = bbx - ac4;
    assign acneg = !r1_sg.cz && (r1_sg.an != r1_sg.cn);

    always_comb begin
        n_info.a_neg   = r1_sg.an;
        n_info.b_pos   = !r1_sg.bn && !r1_sg.bz;
        n_info.lin_neg = (!r1_sg.cn && !r1_sg.cz) != r1_sg.bn;
        n_disc         = acneg ? sum[DW-1:0] : dif[DW-1:0];
        if (r1_sg.az) begin
            if (r1_sg.bz) n_info.code = r1_sg.cz ? CASE_INF : CASE_NOSOL;
            else          n_info.code = CASE_LINEAR;
        end else if (acneg) begin
            n_info.code = CASE_TWO;
        end else if (bbx < ac4) begin
            n_info.code = CASE_NONE;
        end else if (dif == '0) begin
            n_info.code = CASE_DOUBLE;
        end else begin
            n_info.code = CASE_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_info <= n_info;
            r2_disc <= n_disc;
            r2_ua   <= r1_ua;
            r2_ub   <= r1_ub;
            r2_uc   <= r1_uc;
        end
    end

    assign o_info = r2_info;
    assign o_disc = r2_disc;
    assign o_ua   = r2_ua;
    assign o_ub   = r2_ub;
    assign o_uc   = r2_uc;

endmodule

// ----- rtl/core/qrs_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer square root of disc * 4^frac, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
    parameter int SIDE_BITS = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [2*WORD_BITS:0]             i_disc,
    input  logic [SIDE_BITS-1:0]             i_side,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [WORD_BITS+FRAC_BITS:0]     o_root,
    output logic [SIDE_BITS-1:0]             o_side
);
    import qrs_pkg::*;

    localparam int SW = WORD_BITS + FRAC_BITS + 1;
    localparam int RW = 2 * SW;

    logic [RW-1:0]        r_rad  [SW];
    logic [SW+1:0]        r_rem  [SW];
    logic [SW-1:0]        r_root [SW];
    logic [SIDE_BITS-1:0] r_side [SW];
    logic [SW-1:0]        r_v;
    logic [SW:0]          rdy;

    assign rdy[SW]  = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[SW-1];
    assign o_root   = r_root[SW-1];
    assign o_side   = r_side[SW-1];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0]        rad_in;
        logic [SW+1:0]        rem_in;
        logic [SW-1:0]        root_in;
        logic [SIDE_BITS-1:0] side_in;
        logic                 v_in;
        logic [SW+1:0]        rem_sh, trial;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rad_in  = {1'b0, i_disc, {(2*FRAC_BITS){1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_in[SW-1:0], rad_in[RW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_rad[k]  <= {rad_in[RW-3:0], 2'b00};
                r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {root_in[SW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

endmodule

// ----- rtl/core/qrs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// two-lane pipelined restoring divider sharing one divisor, one bit per stage
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_BITS  = 49,
    parameter int DEN_BITS  = 33,
    parameter int SIDE_BITS = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0][NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0]      i_den,
    input  logic [SIDE_BITS-1:0]     i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0][NUM_BITS-1:0] o_quo,
    output logic [SIDE_BITS-1:0]     o_side
);
    import qrs_pkg::*;

    localparam int NB = NUM_BITS;
    localparam int DB = DEN_BITS;

    logic [1:0][NB-1:0]   r_num [NB];
    logic [1:0][NB-1:0]   r_quo [NB];
    logic [1:0][DB-1:0]   r_rem [NB];
    logic [DB-1:0]        r_den [NB];
    logic [SIDE_BITS-1:0] r_side[NB];
    logic [NB-1:0]        r_v;
    logic [NB:0]          rdy;

    assign rdy[NB]  = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[NB-1];
    assign o_quo    = r_quo[NB-1];
    assign o_side   = r_side[NB-1];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [1:0][NB-1:0]   num_in, quo_in, num_nx, quo_nx;
        logic [1:0][DB-1:0]   rem_in, rem_nx;
        logic [DB-1:0]        den_in;
        logic [SIDE_BITS-1:0] side_in;
        logic                 v_in;

        if (k == 0) begin : g_first
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign num_in  = r_num[k-1];
            assign quo_in  = r_quo[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DB:0] sh, sub;
            logic        ge;
            assign sh  = {rem_in[l], num_in[l][NB-1]};
            assign sub = sh - {1'b0, den_in};
            assign ge  = (sh >= {1'b0, den_in});
            assign rem_nx[l] = ge ? sub[DB-1:0] : sh[DB-1:0];
            assign quo_nx[l] = {quo_in[l][NB-2:0], ge};
            assign num_nx[l] = {num_in[l][NB-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_num[k]  <= num_nx;
                r_quo[k]  <= quo_nx;
                r_rem[k]  <= rem_nx;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

endmodule

// ----- rtl/core/qrs_post.sv -----
`timescale 1ns / 1ps
`include "quadratic_root_solver_top_defines.svh"
// ----------------------------------------------------------------------------
// qrs_post
// clamp quotients to the word, order the roots and hold the result (2 stages)
// ----------------------------------------------------------------------------
module qrs_post #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
    parameter int NUM_BITS  = 49
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0][NUM_BITS-1:0]    i_quo,
    input  logic [1:0]                  i_neg,
    input  qrs_pkg::t_info              i_info,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_case_code,
    output logic signed [WORD_BITS-1:0] o_root_low,
    output logic signed [WORD_BITS-1:0] o_root_high,
    output logic                        o_saturated
);
    import qrs_pkg::*;

    localparam int W = WORD_BITS;

    logic [1:0] rdy;
    logic       r_va, r_vb;

    logic signed [W-1:0] r_ra [2];
    logic [1:0]          r_ova;
    t_info               r_infoa;

    t_case               r_code;
    logic signed [W-1:0] r_lo, r_hi;
    logic                r_sat;

    t_case               n_code;
    logic signed [W-1:0] n_lo, n_hi;
    logic                n_sat;

    logic [1:0][W-1:0]   rv;
    logic [1:0]          ov;

    assign rdy[1]  = !r_vb || i_ready;
    assign rdy[0]  = !r_va || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy[0]) r_va <= i_valid;
            if (rdy[1]) r_vb <= r_va;
        end
    end

    // clamp magnitude to 2^(W-1)-1, or 2^(W-1) when negative, then apply sign
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [W-1:0] lim, qv;
        assign lim   = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, i_neg[l]};
        assign ov[l] = (i_quo[l] > {{(NUM_BITS-W){1'b0}}, lim});
        assign qv    = ov[l] ? lim : i_quo[l][W-1:0];
        assign rv[l] = i_neg[l] ? (~qv + 1'b1) : qv;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_ra[0] <= rv[0];
            r_ra[1] <= rv[1];
            r_ova   <= ov;
            r_infoa <= i_info;
        end
    end

    always_comb begin
        n_code = r_infoa.code;
        case (r_infoa.code) inside
            CASE_TWO, CASE_DOUBLE: begin
                n_sat = |r_ova;
                if (r_ra[0] > r_ra[1]) begin
                    n_lo = r_ra[1];
                    n_hi = r_ra[0];
                end else begin
                    n_lo = r_ra[0];
                    n_hi = r_ra[1];
                end
            end
            CASE_LINEAR: begin
                n_sat = r_ova[0];
                n_lo  = r_ra[0];
                n_hi  = r_ra[0];
            end
            default: begin
                n_sat = 1'b0;
                n_lo  = '0;
                n_hi  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_code <= n_code;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_sat  <= n_sat;
        end
    end

    assign o_case_code = r_code;
    assign o_root_low  = r_lo;
    assign o_root_high = r_hi;
    assign o_saturated = r_sat;

    `QRS_ASSERT_NOW(a_root_order, i_clk, i_rst_n,
        r_vb && (r_code == CASE_TWO || r_code == CASE_DOUBLE), r_lo <= r_hi,
        "roots out of order")
    `QRS_ASSERT_NOW(a_single_root, i_clk, i_rst_n,
        r_vb && (r_code == CASE_LINEAR || r_code == CASE_DOUBLE), r_lo == r_hi,
        "single root differs between fields")
    `QRS_ASSERT_NOW(a_no_root_zero, i_clk, i_rst_n,
        r_vb && (r_code == CASE_NONE || r_code == CASE_NOSOL || r_code == CASE_INF),
        r_lo == '0 && r_hi == '0 && !r_sat, "rootless case carries data")
    `QRS_ASSERT_NEXT(a_stage_carry, i_clk, i_rst_n, r_va && rdy[1], r_vb,
        "clamped transaction lost before output")

endmodule
